### rtl/core/humidity_sensor_pulse_receiver_assert.svh
// Assertion macros for the humidity sensor pulse receiver.
// Each macro expects signals clk and rst in the enclosing module.
`ifndef HUMIDITY_SENSOR_PULSE_RECEIVER_ASSERT_SVH
`define HUMIDITY_SENSOR_PULSE_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hspr_pkg.sv
package hspr_pkg;

  // Protocol constants
  localparam int START_MS     = 20;
  localparam int EDGE_COUNT   = 42;
  localparam int SENSOR_COUNT = 6;
  localparam int SKIP_EDGES   = 2;

  // Register defaults and limits
  localparam logic [8:0]  TIMEOUT_RESET   = 9'd100;
  localparam logic [8:0]  TIMEOUT_MIN     = 9'd30;
  localparam logic [8:0]  TIMEOUT_MAX     = 9'd300;
  localparam logic [15:0] THRESHOLD_RESET = 16'd10000;

  // Humidity words at or below this value mark the 16-bit sensor type
  localparam logic signed [15:0] WIDE_LIMIT = 16'sd1000;

  // Divide by ten: q = (m * 52429) >> 19, exact for every 16-bit m
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Register indexes (paddr word bit)
  localparam logic REG_TIMEOUT   = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // Operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_EDGE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_CHECKSUM    = 2'd1;
  localparam logic [1:0] ST_NO_RESPONSE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_START = 3'b010,
    PH_READ  = 3'b100
  } phase_t;

  // Result of the first stage, ahead of the divide
  typedef struct packed {
    logic        accepted;
    logic        drive_low;
    logic [2:0]  selected;
    logic        done;
    logic [1:0]  status;
    logic        wide;
    logic [31:0] bytes;   // b0 in the top byte, zero unless a good read
  } stage_t;

  typedef struct packed {
    logic [12:0] quo;
    logic [3:0]  rem;
  } div10_t;

  // Unsigned 16-bit divide by ten via reciprocal multiply
  function automatic div10_t div10(input logic [15:0] m);
    logic [31:0] prod;
    logic [12:0] q;
    logic [15:0] q10;
    div10_t      res;
    prod    = 32'(m) * 32'(DIV10_RECIP);
    q       = prod[DIV10_SHIFT +: 13];
    q10     = {q[12:0], 3'b000} + {2'b00, q[12:0], 1'b0};
    res.quo = q;
    res.rem = 4'(m - q10);
    return res;
  endfunction

endpackage

### rtl/core/humidity_sensor_pulse_receiver.sv
// A result passes through the first stage register s1 and then the output register.
// Throughput: one item per cycle while the result side keeps up; the state update and
// frame check sit in the first register stage, the divide by ten in the second.
// s_tready drops only while both pipeline registers hold unread results.
// Reset (rst, synchronous) returns to idle, sensor 0, timeout 100, threshold 10000.
`include "humidity_sensor_pulse_receiver_assert.svh"

module humidity_sensor_pulse_receiver
  import hspr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] operation, [4:2] sensor, [20:5] interval, [23:21] zero
  input  logic [23:0] s_tdata,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [1] drive_low, [4:2] selected, [5] done_res, [7:6] status,
  // [8] wide_type, [21:9] hum_high, [30:22] hum_low, [43:31] temp_high,
  // [52:44] temp_low, [55:53] zero
  output logic [55:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [8:0]  timeout_ms;
  logic [15:0] bit_threshold;

  // Read state
  phase_t      phase, phase_next;
  logic [2:0]  chosen_sensor, chosen_sensor_next;
  logic [8:0]  ms_count, ms_count_next;
  logic [5:0]  edge_count, edge_count_next;
  logic [39:0] bit_shift, bit_shift_next;

  // Pipeline
  logic        s1_valid;
  stage_t      s1, s1_next;
  logic        out_valid;
  logic [55:0] out_data, out_data_next;
  logic        out_load, in_accept;

  // Input fields
  logic [1:0]  s_op;
  logic [2:0]  s_sensor;
  logic [15:0] s_interval;

  // Decode helpers
  logic [8:0]  ms_inc;
  logic [5:0]  edge_inc;
  logic        start_ok;
  logic [7:0]  b0, b1, b2, b3, b4;
  logic        csum_ok;
  logic        accepted;
  logic        done;
  logic        frame_done;
  logic [1:0]  status;

  assign s_op       = s_tdata[1:0];
  assign s_sensor   = s_tdata[4:2];
  assign s_interval = s_tdata[20:5];

  // Config port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT:   prdata = {23'd0, timeout_ms};
      REG_THRESHOLD: prdata = {16'd0, bit_threshold};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms    <= TIMEOUT_RESET;
      bit_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_TIMEOUT: begin
          if (pwdata[8:0] >= TIMEOUT_MIN && pwdata[8:0] <= TIMEOUT_MAX) begin
            timeout_ms <= pwdata[8:0];
          end
        end
        REG_THRESHOLD: bit_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: two stages advance independently
  assign out_load  = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || out_load;
  assign in_accept = s_tvalid && s_tready;

  assign ms_inc   = ms_count + 9'd1;
  assign edge_inc = edge_count + 6'd1;
  assign start_ok = (phase == PH_IDLE) && ({1'b0, s_sensor} < 4'(SENSOR_COUNT));

  // State update for one transaction
  always_comb begin
    phase_next         = phase;
    chosen_sensor_next = chosen_sensor;
    ms_count_next      = ms_count;
    edge_count_next    = edge_count;
    bit_shift_next     = bit_shift;
    accepted           = 1'b0;
    done               = 1'b0;
    frame_done         = 1'b0;
    if (in_accept) begin
      case (s_op)
        OP_START: begin
          if (start_ok) begin
            accepted           = 1'b1;
            chosen_sensor_next = s_sensor;
            phase_next         = PH_START;
            ms_count_next      = '0;
            edge_count_next    = '0;
            bit_shift_next     = '0;
          end
        end
        OP_TICK: begin
          if (phase == PH_START) begin
            ms_count_next = ms_inc;
            if (ms_inc >= 9'(START_MS)) begin
              phase_next    = PH_READ;
              ms_count_next = '0;
            end
          end else if (phase == PH_READ) begin
            ms_count_next = ms_inc;
            if (ms_inc >= timeout_ms) begin
              done          = 1'b1;
              phase_next    = PH_IDLE;
              ms_count_next = '0;
            end
          end
        end
        OP_EDGE: begin
          if (phase == PH_READ && s_sensor == chosen_sensor) begin
            if (edge_count >= 6'(SKIP_EDGES)) begin
              bit_shift_next = {bit_shift[38:0], (s_interval > bit_threshold)};
            end
            edge_count_next = edge_inc;
            if (edge_inc >= 6'(EDGE_COUNT)) begin
              done            = 1'b1;
              frame_done      = 1'b1;
              phase_next      = PH_IDLE;
              ms_count_next   = '0;
              edge_count_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Frame check on the updated shift register
  assign b0      = bit_shift_next[39:32];
  assign b1      = bit_shift_next[31:24];
  assign b2      = bit_shift_next[23:16];
  assign b3      = bit_shift_next[15:8];
  assign b4      = bit_shift_next[7:0];
  assign csum_ok = (8'(b0 + b1 + b2 + b3) == b4);

  always_comb begin
    status = ST_OK;
    if (done && !frame_done) begin
      status = ST_NO_RESPONSE;
    end else if (frame_done && !csum_ok) begin
      status = ST_CHECKSUM;
    end
    s1_next.accepted  = accepted;
    s1_next.drive_low = (phase_next == PH_START);
    s1_next.selected  = chosen_sensor_next;
    s1_next.done      = done;
    s1_next.status    = status;
    s1_next.wide      = 1'b0;
    s1_next.bytes     = '0;
    if (done && status == ST_OK) begin
      s1_next.bytes = {b0, b1, b2, b3};
      s1_next.wide  = ($signed({b0, b1}) <= WIDE_LIMIT);
    end
  end

  // Second stage: sign handling and divide by ten for the wide type, bytes passed through otherwise
  logic [15:0] hum_word, hum_mag, temp_mag;
  logic        hum_neg, temp_neg;
  div10_t      hum_div, temp_div;
  logic [12:0] hum_high, temp_high;
  logic [8:0]  hum_low, temp_low;

  assign hum_word = s1.bytes[31:16];
  assign hum_neg  = hum_word[15];
  assign hum_mag  = hum_neg ? 16'(-hum_word) : hum_word;
  assign temp_neg = s1.bytes[15];
  assign temp_mag = {1'b0, s1.bytes[14:0]};
  assign hum_div  = div10(hum_mag);
  assign temp_div = div10(temp_mag);

  always_comb begin
    if (s1.wide) begin
      hum_high  = hum_neg ? 13'(-hum_div.quo) : hum_div.quo;
      hum_low   = hum_neg ? 9'(-{5'd0, hum_div.rem}) : {5'd0, hum_div.rem};
      temp_high = temp_neg ? 13'(-temp_div.quo) : temp_div.quo;
      temp_low  = temp_neg ? 9'(-{5'd0, temp_div.rem}) : {5'd0, temp_div.rem};
    end else begin
      hum_high  = {5'd0, s1.bytes[31:24]};
      hum_low   = {1'b0, s1.bytes[23:16]};
      temp_high = {5'd0, s1.bytes[15:8]};
      temp_low  = {1'b0, s1.bytes[7:0]};
    end
    out_data_next = {3'b000, temp_low, temp_high, hum_low, hum_high, s1.wide,
                     s1.status, s1.done, s1.selected, s1.drive_low, s1.accepted};
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      chosen_sensor <= '0;
      ms_count      <= '0;
      edge_count    <= '0;
      bit_shift     <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      chosen_sensor <= chosen_sensor_next;
      ms_count      <= ms_count_next;
      edge_count    <= edge_count_next;
      bit_shift     <= bit_shift_next;
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Checks
  `HSPR_ASSERT_NOW(a_edge_range, 1'b1, edge_count < 6'(EDGE_COUNT), "edge count out of range")
  `HSPR_ASSERT_NOW(a_idle_ms_clear, phase == PH_IDLE, ms_count == 9'd0, "ms count set while idle")
  `HSPR_ASSERT_NEXT(a_start_taken, accepted, phase == PH_START, "start not taken")
  `HSPR_ASSERT_NOW(a_open_zero, m_tvalid && !m_tdata[5], m_tdata[52:6] == '0, "stray data")
  `HSPR_ASSERT_NOW(a_full_stall, s1_valid && out_valid && !m_tready, !s_tready, "ready while full")

endmodule

### sim/humidity_sensor_pulse_receiver_tb.sv
`default_nettype none

module humidity_sensor_pulse_receiver_tb;
  import hspr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code with no meaning; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // How a generated sensor read ends
  localparam int FRAME_FULL    = 0;
  localparam int FRAME_TIMEOUT = 1;
  localparam int FRAME_PARTIAL = 2;

  localparam int LONG_HOLD    = 300;
  localparam int NUM_SETTINGS = 6;
  localparam int SETTING_ITEMS = 220;

  // Result fields as packed in m_tdata, top bits first
  typedef struct packed {
    logic [2:0]  pad;
    logic [8:0]  temp_low;
    logic [12:0] temp_high;
    logic [8:0]  hum_low;
    logic [12:0] hum_high;
    logic        wide;
    logic [1:0]  status;
    logic        done;
    logic [2:0]  selected;
    logic        drive_low;
    logic        accepted;
  } reading_t;

  // Tracks the reader state and holds the readings still to come
  class frame_scoreboard;
    logic [8:0]  tmo_limit = TIMEOUT_RESET;
    logic [15:0] bit_thr   = THRESHOLD_RESET;
    phase_t      rd_phase  = PH_IDLE;
    logic [2:0]  sel_pin   = '0;
    logic [8:0]  tick_cnt  = '0;
    logic [5:0]  edge_cnt  = '0;
    logic [39:0] bit_buf   = '0;
    reading_t    expected_q[$];
    int          fail_count = 0;

    function void set_reg(logic reg_bit, logic [31:0] value);
      if (reg_bit == REG_TIMEOUT) begin
        if (value[8:0] >= TIMEOUT_MIN && value[8:0] <= TIMEOUT_MAX)
          tmo_limit = value[8:0];
      end else begin
        bit_thr = value[15:0];
      end
    endfunction

    // Split the 40 received bits into bytes and fill in the reading
    function void decode_frame(inout reading_t r);
      logic [7:0] b0, b1, b2, b3, b4, sum;
      int hum, temp;
      {b0, b1, b2, b3, b4} = bit_buf;
      sum = b0 + b1 + b2 + b3;
      if (sum != b4) begin
        r.status = ST_CHECKSUM;
      end else begin
        r.status = ST_OK;
        hum = $signed({b0, b1});
        if (hum <= 1000) begin
          // temperature is sign-magnitude
          temp = {b2[6:0], b3};
          if (b2[7])
            temp = -temp;
          r.wide      = 1'b1;
          r.hum_high  = 13'(hum / 10);
          r.hum_low   = 9'(hum % 10);
          r.temp_high = 13'(temp / 10);
          r.temp_low  = 9'(temp % 10);
        end else begin
          r.hum_high  = {5'd0, b0};
          r.hum_low   = {1'b0, b1};
          r.temp_high = {5'd0, b2};
          r.temp_low  = {1'b0, b3};
        end
      end
    endfunction

    // Advance the reader by one accepted input and queue its reading
    function void take_item(logic [1:0] op, logic [2:0] sen, logic [15:0] ivl);
      reading_t r;
      r = '0;
      case (op)
        OP_START: begin
          if (rd_phase == PH_IDLE && sen < SENSOR_COUNT) begin
            r.accepted = 1'b1;
            sel_pin  = sen;
            rd_phase = PH_START;
            tick_cnt = '0;
            edge_cnt = '0;
            bit_buf  = '0;
          end
        end
        OP_TICK: begin
          if (rd_phase == PH_START) begin
            tick_cnt = tick_cnt + 9'd1;
            if (tick_cnt >= START_MS) begin
              rd_phase = PH_READ;
              tick_cnt = '0;
            end
          end else if (rd_phase == PH_READ) begin
            tick_cnt = tick_cnt + 9'd1;
            if (tick_cnt >= tmo_limit) begin
              r.done   = 1'b1;
              r.status = ST_NO_RESPONSE;
              rd_phase = PH_IDLE;
              tick_cnt = '0;
            end
          end
        end
        OP_EDGE: begin
          if (rd_phase == PH_READ && sen == sel_pin) begin
            if (edge_cnt >= SKIP_EDGES)
              bit_buf = {bit_buf[38:0], ivl > bit_thr};
            edge_cnt = edge_cnt + 6'd1;
            if (edge_cnt >= EDGE_COUNT) begin
              r.done = 1'b1;
              decode_frame(r);
              rd_phase = PH_IDLE;
              tick_cnt = '0;
              edge_cnt = '0;
            end
          end
        end
        default: ;
      endcase
      r.drive_low = (rd_phase == PH_START);
      r.selected  = sel_pin;
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
        fail_count++;
      end
    endfunction

    function void check_result(logic [55:0] data);
      reading_t act, exp_r;
      act = data;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected reading: expected none, actual %0h", $time, data);
        fail_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      cmp("accepted", exp_r.accepted, act.accepted);
      cmp("drive_low", exp_r.drive_low, act.drive_low);
      cmp("selected", exp_r.selected, act.selected);
      cmp("done_res", exp_r.done, act.done);
      cmp("status", exp_r.status, act.status);
      cmp("wide_type", exp_r.wide, act.wide);
      cmp("hum_high", exp_r.hum_high, act.hum_high);
      cmp("hum_low", exp_r.hum_low, act.hum_low);
      cmp("temp_high", exp_r.temp_high, act.temp_high);
      cmp("temp_low", exp_r.temp_low, act.temp_low);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [1:0] operation, [4:2] sensor, [20:5] interval, [23:21] zero
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] accepted, [1] drive_low, [4:2] selected, [5] done_res, [7:6] status,
  // [8] wide_type, [21:9] hum_high, [30:22] hum_low, [43:31] temp_high,
  // [52:44] temp_low, [55:53] zero
  logic [55:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  int items_sent = 0;
  bit sender_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req = 1'b0;

  always #6 clk = ~clk;

  humidity_sensor_pulse_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Offer one item, now and then with a random gap first while sender_idle is set; valid stays high afterwards
  task automatic send_item(input logic [1:0] op, input logic [2:0] sen,
                           input logic [15:0] ivl);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, ivl, sen, op};
    do @(posedge clk); while (!s_tready);
    sb.take_item(op, sen, ivl);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding reading
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup, access, then idle
  task automatic write_reg(input logic reg_bit, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_bit, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(reg_bit, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Fully random item, any code, pin and interval
  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 16'($urandom));
  endtask

  // Stray item that must not disturb the read on the given pin
  task automatic send_stray(input logic [2:0] pin);
    logic [2:0] other;
    other = pin + 3'($urandom_range(1, 7));
    case ($urandom_range(0, 2))
      0: send_item(OP_EDGE, other, 16'($urandom));
      1: send_item(OP_START, 3'($urandom_range(0, 7)), 16'($urandom));
      default: send_item(OP_UNUSED, 3'($urandom_range(0, 7)), 16'($urandom));
    endcase
  endtask

  // One sensor read: start, start ticks, then edges carrying all or part of a 40-bit frame
  task automatic read_frame(input int mode);
    logic [2:0]  pin;
    logic [15:0] hum_w, temp_w, ivl;
    logic [7:0]  sum;
    logic [39:0] frame;
    int nedges;
    pin = 3'($urandom_range(0, SENSOR_COUNT - 1));
    case ($urandom_range(0, 7))
      0: hum_w = 16'h8000;
      1: hum_w = 16'd1000;
      2: hum_w = 16'd1001;
      3: hum_w = 16'hFFFF;
      4: hum_w = 16'h7FFF;
      5: hum_w = 16'($urandom_range(0, 1000));
      default: hum_w = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: temp_w = 16'h8000;
      1: temp_w = 16'h7FFF;
      2: temp_w = 16'hFFFF;
      3: temp_w = {1'($urandom), 15'($urandom_range(0, 800))};
      default: temp_w = 16'($urandom);
    endcase
    sum = hum_w[15:8] + hum_w[7:0] + temp_w[15:8] + temp_w[7:0];
    if ($urandom_range(0, 5) == 0)
      sum = sum ^ (8'd1 << $urandom_range(0, 7));
    frame = {hum_w, temp_w, sum};

    // finish whatever read is still going
    while (sb.rd_phase != PH_IDLE)
      send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
    send_item(OP_START, pin, 16'($urandom));
    for (int i = 0; i < START_MS; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // an edge on the selected pin is ignored while the line is held low
        if ($urandom_range(0, 1) == 0)
          send_item(OP_EDGE, pin, 16'($urandom));
        else
          send_stray(pin);
      end
      send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
    end

    nedges = (mode == FRAME_FULL) ? EDGE_COUNT : $urandom_range(0, EDGE_COUNT - 1);
    for (int k = 0; k < nedges; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_stray(pin);
      if ($urandom_range(0, 9) == 0)
        send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
      if (k < SKIP_EDGES)
        ivl = 16'($urandom);
      else if (frame[39 - (k - SKIP_EDGES)] && sb.bit_thr != 16'hFFFF)
        ivl = 16'($urandom_range(65535, int'(sb.bit_thr) + 1));
      else if (frame[39 - (k - SKIP_EDGES)])
        ivl = 16'hFFFF;
      else
        ivl = 16'($urandom_range(int'(sb.bit_thr), 0));
      send_item(OP_EDGE, pin, ivl);
    end

    if (mode == FRAME_TIMEOUT) begin
      while (sb.rd_phase == PH_READ)
        send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
    end else if (mode == FRAME_PARTIAL) begin
      repeat ($urandom_range(0, 60))
        send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
    end
  endtask

  // Register values for one setting; an out-of-range timeout goes first
  task automatic apply_setting(input int idx);
    logic [8:0]  tmo, bad;
    logic [15:0] thr;
    case (idx)
      1: begin
        tmo = TIMEOUT_MIN;
        thr = 16'd0;
        bad = 9'd29;
      end
      2: begin
        tmo = TIMEOUT_MAX;
        thr = 16'hFFFF;
        bad = 9'd301;
      end
      default: begin
        tmo = 9'($urandom_range(30, 300));
        thr = 16'($urandom);
        bad = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 29))
                                          : 9'($urandom_range(301, 511));
      end
    endcase
    write_reg(REG_TIMEOUT, (32'($urandom) & 32'hFFFF_FE00) | 32'(bad));
    write_reg(REG_TIMEOUT, (32'($urandom) & 32'hFFFF_FE00) | 32'(tmo));
    write_reg(REG_THRESHOLD, (32'($urandom) & 32'hFFFF_0000) | 32'(thr));
  endtask

  // Check every reading the block hands over
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
  end

  // Result side: random stalls, stretches of ready, one long hold-off
  initial begin : result_sink
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int budget, pick, wait_cycles;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Items the block must ignore or refuse, at field extremes
    send_item(OP_TICK, 3'd0, 16'd0);
    send_item(OP_EDGE, 3'd0, 16'd0);
    send_item(OP_EDGE, 3'd7, 16'hFFFF);
    send_item(OP_UNUSED, 3'd7, 16'hFFFF);
    send_item(OP_UNUSED, 3'd0, 16'd0);
    send_item(OP_START, 3'd6, 16'd0);
    send_item(OP_START, 3'd7, 16'hFFFF);
    // accepted start for the highest sensor, then a start while busy
    send_item(OP_START, 3'd5, 16'hFFFF);
    send_item(OP_START, 3'd0, 16'd0);
    send_item(OP_EDGE, 3'd5, 16'hFFFF);
    send_item(OP_UNUSED, 3'd5, 16'd0);
    send_item(OP_TICK, 3'd7, 16'hFFFF);

    // Random reads under several register settings
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        // leave a read open so the new timeout lands in the middle of it
        read_frame(FRAME_PARTIAL);
        drain();
        apply_setting(s);
      end
      if (s == 2)
        hold_req = 1'b1;
      if (s == NUM_SETTINGS - 1) begin
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
      end
      budget = items_sent + SETTING_ITEMS;
      while (items_sent < budget) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)
          read_frame(FRAME_FULL);
        else if (pick < 16)
          read_frame(FRAME_TIMEOUT);
        else
          repeat ($urandom_range(1, 8)) send_noise();
      end
    end

    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (sb.expected_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d readings never arrived", $time, sb.expected_q.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/hspr_pkg.sv
rtl/core/humidity_sensor_pulse_receiver.sv
sim/humidity_sensor_pulse_receiver_tb.sv
